/* rtl/ictf_pkg.sv */
// Shared types, sequencer codes and constants for the complementary tilt filter.
// Used by ictf_ctrl, ictf_dp and the top level; depends on nothing else.
package ictf_pkg;

    // Sequencer step codes; the controller state doubles as the datapath command.
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SQ_INIT  = 5'd1;
    localparam logic [4:0] S_SQ_STEP  = 5'd2;
    localparam logic [4:0] S_CO_INIT  = 5'd3;
    localparam logic [4:0] S_CO_STEP  = 5'd4;
    localparam logic [4:0] S_CO_DONE  = 5'd5;
    localparam logic [4:0] S_G_MUL    = 5'd6;
    localparam logic [4:0] S_G_DIVLD  = 5'd7;
    localparam logic [4:0] S_DV_MUL   = 5'd8;
    localparam logic [4:0] S_DV_COR   = 5'd9;
    localparam logic [4:0] S_G_STORE  = 5'd10;
    localparam logic [4:0] S_W_SUM    = 5'd11;
    localparam logic [4:0] S_W_DIVLD  = 5'd12;
    localparam logic [4:0] S_W_KMUL   = 5'd13;
    localparam logic [4:0] S_W_APP    = 5'd14;
    localparam logic [4:0] S_B_MUL    = 5'd15;
    localparam logic [4:0] S_B_ADD    = 5'd16;
    localparam logic [4:0] S_FIN      = 5'd17;

    // Register index of the gyro weight.
    localparam logic REG_GYRO_WEIGHT = 1'b0;
    localparam logic [15:0] GYRO_WEIGHT_RST = 16'd64225;

    // Iteration counter width and square-root step count.
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned SQRT_STEPS = 24;

    // CORDIC constants, angle accumulator in 2^-15 degree.
    localparam logic signed [24:0] QUARTER_TURN = 25'sd2949120;

    // Angle limits in 1/128 degree.
    localparam logic signed [25:0] LIM_X = 26'sd23040;
    localparam logic signed [25:0] LIM_Y = 26'sd11520;

    // Reciprocal constants for division by 125 and 45 (scaled by 2^37).
    localparam int unsigned RECIP_SHIFT = 37;
    localparam logic [31:0] RECIP_125 = 32'd1099511627;
    localparam logic [31:0] RECIP_45  = 32'd3054198966;
    localparam logic [6:0]  DIV_125   = 7'd125;
    localparam logic [6:0]  DIV_45    = 7'd45;

    // Command from controller to datapath.
    typedef struct packed {
        logic [4:0]       op;
        logic             load;
        logic             out_load;
        logic             pass;
        logic             lane;
        logic [1:0]       gi;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic in_range;
    } t_stat;

    // Arctangent of 2^-i in 2^-15 degree.
    function automatic logic signed [24:0] atan_entry(input logic [CNT_W-1:0] idx);
        logic signed [24:0] v;
        case (idx)
            5'd0:    v = 25'sd1474560;
            5'd1:    v = 25'sd870484;
            5'd2:    v = 25'sd459940;
            5'd3:    v = 25'sd233473;
            5'd4:    v = 25'sd117189;
            5'd5:    v = 25'sd58652;
            5'd6:    v = 25'sd29333;
            5'd7:    v = 25'sd14667;
            5'd8:    v = 25'sd7334;
            5'd9:    v = 25'sd3667;
            5'd10:   v = 25'sd1833;
            5'd11:   v = 25'sd917;
            5'd12:   v = 25'sd458;
            5'd13:   v = 25'sd229;
            5'd14:   v = 25'sd115;
            5'd15:   v = 25'sd57;
            5'd16:   v = 25'sd29;
            5'd17:   v = 25'sd14;
            5'd18:   v = 25'sd7;
            5'd19:   v = 25'sd4;
            5'd20:   v = 25'sd2;
            5'd21:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/ictf_ctrl.sv */
// Sequencer for the tilt filter: walks the square root, CORDIC, divide,
// wrap and blend steps and owns both handshakes. Depends on ictf_pkg.
module ictf_ctrl import ictf_pkg::*; #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_pass, n_pass;
    logic             r_lane, n_lane;
    logic [1:0]       r_gi, n_gi;
    logic             r_wrap, n_wrap;
    logic             r_ovalid, n_ovalid;
    logic             accept;
    logic             out_load;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_load = (r_state == S_FIN) && (!r_ovalid || !i_out_stall);

    // Next-state logic.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pass   = r_pass;
        n_lane   = r_lane;
        n_gi     = r_gi;
        n_wrap   = r_wrap;
        n_ovalid = r_ovalid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SQ_INIT;
                    n_pass  = 1'b0;
                end
            end
            S_SQ_INIT: begin
                n_cnt   = '0;
                n_state = S_SQ_STEP;
            end
            S_SQ_STEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) n_state = S_CO_INIT;
            end
            S_CO_INIT: begin
                n_cnt   = '0;
                n_state = S_CO_STEP;
            end
            S_CO_STEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) n_state = S_CO_DONE;
            end
            S_CO_DONE: begin
                if (!r_pass) begin
                    n_pass  = 1'b1;
                    n_state = S_SQ_INIT;
                end else begin
                    n_gi    = 2'd0;
                    n_state = S_G_MUL;
                end
            end
            S_G_MUL: begin
                n_wrap  = 1'b0;
                n_state = S_G_DIVLD;
            end
            S_G_DIVLD: n_state = S_DV_MUL;
            S_DV_MUL:  n_state = S_DV_COR;
            S_DV_COR:  n_state = r_wrap ? S_W_KMUL : S_G_STORE;
            S_G_STORE: begin
                if (r_gi == 2'd2) begin
                    n_lane  = 1'b0;
                    n_state = S_W_SUM;
                end else begin
                    n_gi    = r_gi + 2'd1;
                    n_state = S_G_MUL;
                end
            end
            S_W_SUM: n_state = S_W_DIVLD;
            S_W_DIVLD: begin
                if (i_stat.in_range) begin
                    n_state = S_B_MUL;
                end else begin
                    n_wrap  = 1'b1;
                    n_state = S_DV_MUL;
                end
            end
            S_W_KMUL: n_state = S_W_APP;
            S_W_APP:  n_state = S_B_MUL;
            S_B_MUL:  n_state = S_B_ADD;
            S_B_ADD: begin
                if (!r_lane) begin
                    n_lane  = 1'b1;
                    n_state = S_W_SUM;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pass   <= 1'b0;
            r_lane   <= 1'b0;
            r_gi     <= 2'd0;
            r_wrap   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pass   <= n_pass;
            r_lane   <= n_lane;
            r_gi     <= n_gi;
            r_wrap   <= n_wrap;
            r_ovalid <= n_ovalid;
        end
    end

    // Command to the datapath.
    always_comb begin
        o_cmd.op       = r_state;
        o_cmd.load     = accept;
        o_cmd.out_load = out_load;
        o_cmd.pass     = r_pass;
        o_cmd.lane     = r_lane;
        o_cmd.gi       = r_gi;
        o_cmd.cnt      = r_cnt;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

endmodule

/* rtl/ictf_dp.sv */
// Datapath of the tilt filter: square root, CORDIC, reciprocal divider,
// wrap and blend registers, driven step by step by ictf_ctrl. Depends on ictf_pkg.
module ictf_dp import ictf_pkg::*; (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic [15:0]        i_weight,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic [31:0]        i_time_now_ms,
    input  logic               i_rst_n,
    output t_stat              o_stat,
    output logic signed [15:0] o_tilt_x,
    output logic signed [14:0] o_tilt_y,
    output logic signed [31:0] o_yaw_z
);

    // Sample registers.
    logic signed [15:0] r_ax, r_ay, r_gx, r_gy, r_gz;
    logic               r_sgz;
    logic [15:0]        r_dt;
    logic [30:0]        r_sqz;
    // Filter state.
    logic [31:0]        r_last;
    logic signed [15:0] r_estx;
    logic signed [14:0] r_esty;
    logic signed [31:0] r_zsum;
    // Working registers.
    logic [47:0]        r_rem, r_root, r_bit;
    logic signed [27:0] r_cx, r_cy;
    logic signed [24:0] r_cz;
    logic signed [15:0] r_accx, r_accy;
    logic signed [32:0] r_p;
    logic               r_neg;
    logic [29:0]        r_dvn;
    logic               r_dv45;
    logic [61:0]        r_dvprod;
    logic [24:0]        r_q;
    logic signed [24:0] r_dgx, r_dgy, r_dgz;
    logic signed [25:0] r_a;
    logic [25:0]        r_km;
    logic signed [32:0] r_bprod;

    // Combinational step logic.
    logic signed [15:0] sq_op;
    logic signed [31:0] sq_a;
    logic [31:0]        sq_sum;
    logic [47:0]        sq_try;
    logic [31:0]        diff;
    logic signed [15:0] co_yop;
    logic signed [27:0] co_xin, co_yin, co_dx, co_dy;
    logic signed [24:0] co_atan, co_round;
    logic signed [15:0] g_sel;
    logic signed [32:0] g_prod;
    logic [32:0]        g_mag;
    logic [31:0]        g_n;
    logic [61:0]        dv_prod;
    logic [24:0]        dv_q0;
    logic [6:0]         dv_d;
    logic [31:0]        dv_rem;
    logic [24:0]        dv_q;
    logic signed [24:0] dg_val;
    logic signed [25:0] w_lim, w_n;
    logic [15:0]        w_span;
    logic               w_gt, w_lt;
    logic [31:0]        w_km;
    logic signed [16:0] b_term;
    logic signed [17:0] b_sum, b_wrap;

    always_comb begin
        diff   = i_time_now_ms - r_last;
        // Square root operand: z squared plus x or y squared, shifted up 16.
        sq_op  = i_cmd.pass ? r_ay : r_ax;
        sq_a   = sq_op * sq_op;
        sq_sum = {1'b0, r_sqz} + {1'b0, sq_a[30:0]};
        sq_try = r_root + r_bit;
        // CORDIC start vector with the half-plane pre-rotation.
        co_yop = i_cmd.pass ? r_ax : r_ay;
        co_yin = {{4{co_yop[15]}}, co_yop, 8'b0};
        if (i_cmd.pass || r_sgz) co_xin = $signed({4'b0, r_root[23:0]});
        else                     co_xin = -$signed({4'b0, r_root[23:0]});
        co_dx    = r_cy >>> i_cmd.cnt;
        co_dy    = r_cx >>> i_cmd.cnt;
        co_atan  = atan_entry(i_cmd.cnt);
        co_round = (r_cz + 25'sd128) >>> 8;
        // Gyro increment numerator.
        case (i_cmd.gi)
            2'd0:    g_sel = r_gx;
            2'd1:    g_sel = r_gy;
            default: g_sel = r_gz;
        endcase
        g_prod = g_sel * $signed({1'b0, r_dt});
        g_mag  = r_p[32] ? 33'(-r_p) : 33'(r_p);
        g_n    = g_mag[31:0] + 32'd250;
        // Reciprocal divide with one correction step.
        dv_prod = r_dvn * (r_dv45 ? RECIP_45 : RECIP_125);
        dv_q0   = r_dvprod[61:RECIP_SHIFT];
        dv_d    = r_dv45 ? DIV_45 : DIV_125;
        dv_rem  = {2'b0, r_dvn} - 32'(dv_q0 * dv_d);
        dv_q    = dv_q0 + ((dv_rem >= {25'b0, dv_d}) ? 25'd1 : 25'd0);
        dg_val  = r_neg ? -$signed(r_q) : $signed(r_q);
        // Wrap of the inner angle.
        w_lim  = i_cmd.lane ? LIM_Y : LIM_X;
        w_span = 16'(2 * w_lim);
        w_gt   = r_a > w_lim;
        w_lt   = r_a < -w_lim;
        w_n    = w_gt ? (r_a + w_lim - 26'sd1) : (w_lim - 26'sd1 - r_a);
        w_km   = r_q[15:0] * w_span;
        // Blend and final wrap.
        b_term = 17'((r_bprod + 33'sd32768) >>> 16);
        b_sum  = (i_cmd.lane ? r_accy : r_accx) + b_term;
        if (b_sum > 18'(w_lim))        b_wrap = b_sum - 18'(2 * w_lim);
        else if (b_sum < -18'(w_lim))  b_wrap = b_sum + 18'(2 * w_lim);
        else                           b_wrap = b_sum;
    end

    assign o_stat.in_range = !w_gt && !w_lt;

    // Filter state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_estx <= '0;
            r_esty <= '0;
            r_zsum <= '0;
        end else begin
            if (i_cmd.load) r_last <= i_time_now_ms;
            if (i_cmd.op == S_B_ADD) begin
                if (i_cmd.lane) r_esty <= b_wrap[14:0];
                else            r_estx <= b_wrap[15:0];
            end
            if (i_cmd.op == S_G_STORE && i_cmd.gi == 2'd2)
                r_zsum <= r_zsum + 32'(dg_val);
        end
    end

    // Working registers, stepped by the command.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax  <= i_accel_x;
            r_ay  <= i_accel_y;
            r_gx  <= i_gyro_x;
            r_gy  <= i_gyro_y;
            r_gz  <= i_gyro_z;
            r_sgz <= !i_accel_z[15];
            r_sqz <= 31'(i_accel_z * i_accel_z);
            r_dt  <= (diff > 32'd65535) ? 16'hFFFF : diff[15:0];
        end
        case (i_cmd.op)
            S_SQ_INIT: begin
                r_rem  <= {sq_sum, 16'b0};
                r_root <= '0;
                r_bit  <= 48'd1 << 46;
            end
            S_SQ_STEP: begin
                if (r_rem >= sq_try) begin
                    r_rem  <= r_rem - sq_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_CO_INIT: begin
                if (co_xin < 0) begin
                    if (co_yin >= 0) begin
                        r_cx <= co_yin;
                        r_cy <= -co_xin;
                        r_cz <= QUARTER_TURN;
                    end else begin
                        r_cx <= -co_yin;
                        r_cy <= co_xin;
                        r_cz <= -QUARTER_TURN;
                    end
                end else begin
                    r_cx <= co_xin;
                    r_cy <= co_yin;
                    r_cz <= '0;
                end
            end
            S_CO_STEP: begin
                if (r_cy >= 0) begin
                    r_cx <= r_cx + co_dx;
                    r_cy <= r_cy - co_dy;
                    r_cz <= r_cz + co_atan;
                end else begin
                    r_cx <= r_cx - co_dx;
                    r_cy <= r_cy + co_dy;
                    r_cz <= r_cz - co_atan;
                end
            end
            S_CO_DONE: begin
                if (i_cmd.pass) r_accy <= -co_round[15:0];
                else            r_accx <= co_round[15:0];
            end
            S_G_MUL: r_p <= g_prod;
            S_G_DIVLD: begin
                r_neg  <= r_p[32];
                r_dvn  <= g_n[31:2];
                r_dv45 <= 1'b0;
            end
            S_DV_MUL: r_dvprod <= dv_prod;
            S_DV_COR: r_q <= dv_q;
            S_G_STORE: begin
                case (i_cmd.gi)
                    2'd0:    r_dgx <= dg_val;
                    2'd1:    r_dgy <= dg_val;
                    default: r_dgz <= dg_val;
                endcase
            end
            S_W_SUM: begin
                if (!i_cmd.lane)  r_a <= r_estx - r_dgx - r_accx;
                else if (r_sgz)   r_a <= r_esty + r_dgy - r_accy;
                else              r_a <= r_esty - r_dgy - r_accy;
            end
            S_W_DIVLD: begin
                r_dvn  <= i_cmd.lane ? 30'(w_n >>> 9) : 30'(w_n >>> 10);
                r_dv45 <= 1'b1;
            end
            S_W_KMUL: r_km <= w_km[25:0];
            S_W_APP: begin
                if (w_gt) r_a <= r_a - $signed(r_km);
                else      r_a <= r_a + $signed(r_km);
            end
            S_B_MUL: r_bprod <= $signed({1'b0, i_weight}) * $signed(r_a[15:0]);
            default: ;
        endcase
        if (i_cmd.out_load) begin
            o_tilt_x <= r_estx;
            o_tilt_y <= r_esty;
            o_yaw_z  <= r_zsum;
        end
    end

endmodule

/* rtl/imu_complementary_tilt_filter.sv */
// Top level of the IMU complementary tilt filter: configuration register,
// APB access and the controller/datapath pair. Depends on ictf_pkg, ictf_ctrl, ictf_dp.
//
// One sample in, one result out. Each sample passes through the two 24-step
// bit-serial square roots and the two CORDIC passes, which run on one shared
// iterative datapath, followed by three reciprocal divides of the gyro
// increments. Each of the x and y inner angles that lies outside its range
// takes a further reciprocal divide by 45 to wrap it. Input is taken again as
// soon as the sequencer is idle, while the previous result may still wait in
// the output register.
module imu_complementary_tilt_filter import ictf_pkg::*; #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Sample channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic [31:0]        i_time_now_ms,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_tilt_x,
    output logic signed [14:0] o_tilt_y,
    output logic signed [31:0] o_yaw_z,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] r_gyro_weight;
    t_cmd        cmd;
    t_stat       stat;

    // Gyro weight register; writes to other addresses are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_weight <= GYRO_WEIGHT_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_GYRO_WEIGHT) begin
            r_gyro_weight <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_GYRO_WEIGHT) ? {16'b0, r_gyro_weight} : 32'b0;
    assign pready = 1'b1;

    ictf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ictf_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_weight      (r_gyro_weight),
        .i_accel_x     (i_accel_x),
        .i_accel_y     (i_accel_y),
        .i_accel_z     (i_accel_z),
        .i_gyro_x      (i_gyro_x),
        .i_gyro_y      (i_gyro_y),
        .i_gyro_z      (i_gyro_z),
        .i_time_now_ms (i_time_now_ms),
        .i_rst_n       (i_rst_n),
        .o_stat        (stat),
        .o_tilt_x      (o_tilt_x),
        .o_tilt_y      (o_tilt_y),
        .o_yaw_z       (o_yaw_z)
    );

endmodule
